>>> rtl/c3bsf_pkg.sv
package c3bsf_pkg;

	localparam int CRC_WIDTH = 3;
	localparam int FLAG_LEN = 4;
	localparam int RUN_LIMIT = 3;
	localparam int QUEUE_DEPTH = 4;

	// wide enough for a flag count and a crc bit index
	localparam int CNT_W = $clog2(FLAG_LEN);
	localparam int RUN_W = 2;

	localparam logic [CRC_WIDTH-1:0] POLY_RESET = CRC_WIDTH'(3);

	localparam logic [1:0] KIND_FLAG = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STUFF = 2'd2;
	localparam logic [1:0] KIND_CRC = 2'd3;

	typedef struct packed {
		logic data_bit;
		logic frame_end;
	} in_item_t;

	typedef struct packed {
		logic line_bit;
		logic [1:0] bit_kind;
		logic last_out;
	} out_item_t;

	// one accepted item as the back end sees it
	typedef struct packed {
		logic data_bit;
		logic frame_end;
		logic frame_start;
		logic [CRC_WIDTH-1:0] crc;
	} work_t;

endpackage

>>> rtl/c3bsf_front.sv
module c3bsf_front
	import c3bsf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	input logic cfg_we,
	input logic [CRC_WIDTH-1:0] cfg_wdata,
	output logic push_valid,
	input logic push_ready,
	output work_t push_data
);

	logic [CRC_WIDTH-1:0] poly_q;
	logic [CRC_WIDTH-1:0] crc_q;
	logic inside_q;
	logic [CRC_WIDTH-1:0] crc_base;
	logic [CRC_WIDTH-1:0] crc_shift;
	logic [CRC_WIDTH-1:0] crc_new;
	logic fb;
	logic accept;

	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign accept = in_valid && push_ready;

	always_comb begin
		crc_base = inside_q ? crc_q : '0;
		fb = crc_base[CRC_WIDTH-1] ^ in_data.data_bit;
		crc_shift = {crc_base[CRC_WIDTH-2:0], 1'b0};
		crc_new = fb ? (crc_shift ^ poly_q) : crc_shift;
		push_data.data_bit = in_data.data_bit;
		push_data.frame_end = in_data.frame_end;
		push_data.frame_start = !inside_q;
		push_data.crc = crc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			crc_q <= '0;
			inside_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				poly_q <= cfg_wdata;
			end
			if (accept) begin
				crc_q <= in_data.frame_end ? '0 : crc_new;
				inside_q <= !in_data.frame_end;
			end
		end
	end

endmodule

>>> rtl/c3bsf_queue.sv
module c3bsf_queue
	import c3bsf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input work_t push_data,
	output logic head_valid,
	output work_t head_data,
	input logic pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	work_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CNT_W_Q'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/c3bsf_back.sv
module c3bsf_back
	import c3bsf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input work_t head_data,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);

	localparam logic [1:0] PH_OPEN = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_CRC = 2'd2;
	localparam logic [1:0] PH_CLOSE = 2'd3;

	logic [1:0] phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RUN_W-1:0] run_q;
	logic busy_q;
	logic out_valid_q;
	out_item_t out_data_q;

	logic [1:0] cur_phase;
	logic [CNT_W-1:0] cur_cnt;
	logic [1:0] phase_d;
	logic [CNT_W-1:0] cnt_d;
	logic [RUN_W-1:0] run_d;
	logic busy_d;
	logic emit;
	logic src_bit;
	logic need_stuff;
	logic [CNT_W-1:0] crc_idx;
	out_item_t bit_d;

	assign emit = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		cur_phase = busy_q ? phase_q : (head_data.frame_start ? PH_OPEN : PH_DATA);
		cur_cnt = busy_q ? cnt_q : '0;
		crc_idx = CNT_W'(CRC_WIDTH - 1) - cur_cnt;
		src_bit = (cur_phase == PH_DATA) ? head_data.data_bit : head_data.crc[crc_idx];
		// a one after a full run of ones gets a zero in front of it
		need_stuff = src_bit && (run_q >= RUN_W'(RUN_LIMIT));

		phase_d = cur_phase;
		cnt_d = cur_cnt;
		run_d = run_q;
		busy_d = 1'b1;
		pop = 1'b0;
		bit_d = '{line_bit: 1'b1, bit_kind: KIND_FLAG, last_out: 1'b0};

		unique case (cur_phase)
			PH_OPEN: begin
				if (cur_cnt == CNT_W'(FLAG_LEN - 1)) begin
					phase_d = PH_DATA;
					cnt_d = '0;
				end else begin
					cnt_d = cur_cnt + 1'b1;
				end
			end
			PH_DATA, PH_CRC: begin
				if (need_stuff) begin
					// the stuffed zero breaks the run, the held one then counts as the first
					bit_d = '{line_bit: 1'b0, bit_kind: KIND_STUFF, last_out: 1'b0};
					run_d = '0;
				end else begin
					bit_d.line_bit = src_bit;
					bit_d.bit_kind = (cur_phase == PH_DATA) ? KIND_PAYLOAD : KIND_CRC;
					run_d = src_bit ? run_q + 1'b1 : '0;
					if (cur_phase == PH_DATA) begin
						if (head_data.frame_end) begin
							phase_d = PH_CRC;
							cnt_d = '0;
						end else begin
							pop = emit;
							busy_d = 1'b0;
						end
					end else if (cur_cnt == CNT_W'(CRC_WIDTH - 1)) begin
						phase_d = PH_CLOSE;
						cnt_d = '0;
					end else begin
						cnt_d = cur_cnt + 1'b1;
					end
				end
			end
			PH_CLOSE: begin
				if (cur_cnt == CNT_W'(FLAG_LEN - 1)) begin
					bit_d.last_out = 1'b1;
					pop = emit;
					busy_d = 1'b0;
					run_d = '0;
				end else begin
					cnt_d = cur_cnt + 1'b1;
				end
			end
			default: begin
				busy_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			cnt_q <= '0;
			run_q <= '0;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= phase_d;
				cnt_q <= cnt_d;
				run_q <= run_d;
				busy_q <= busy_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= bit_d;
		end
	end

endmodule

>>> rtl/crc3_bit_stuffing_framer_core.sv
// Serial frame encoder with CRC-3 and bit stuffing. Each input item is one
// payload bit with a frame_end mark; each output item is one line bit with its
// kind (flag, payload, stuffed zero, crc) and a last mark on the final closing
// flag. The front end computes the crc as items are accepted, one item per cycle
// unless the queue is full, and passes them through a DEPTH-entry queue; the back
// end puts out one line bit per cycle from a registered output unless out_ready
// is low or the queue is empty. A frame goes out as 4 opening flag bits, its
// payload bits with any stuffed zeros, 3 or 4 bits of crc and stuffing, and 4
// closing flag bits. The sustained rate is set by the back end's output, and the
// input stalls only when the queue is full. poly_q is written through
// cfg_we/cfg_wdata by the user while the block is idle; the block does not check.
module crc3_bit_stuffing_framer_core
	import c3bsf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [CRC_WIDTH-1:0] cfg_wdata
);

	logic push_valid;
	logic push_ready;
	work_t push_data;
	logic head_valid;
	work_t head_data;
	logic pop;

	c3bsf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	c3bsf_queue #(
		.DEPTH(DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop)
	);

	c3bsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
